FILE: sv/mss_pkg.sv
// Shared types and fixed field widths for the median-of-sample-set block.
// Used by mss_cell and median_of_sample_set_core; depends on nothing.
package mss_pkg;

	// Fixed field widths of the stream items
	localparam int SAMPLE_W   = 16;
	localparam int MEDIAN_W   = 17;
	localparam int SIZE_W     = 9;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 32;

	// Bit positions of the result fields in the output tdata
	localparam int MEDIAN_LSB = 0;
	localparam int SIZE_LSB   = MEDIAN_LSB + MEDIAN_W;
	localparam int OVF_BIT    = SIZE_LSB + SIZE_W;

	// Command broadcast along the chain each cycle
	typedef struct packed {
		logic ins;   // insert the broadcast sample in order
		logic shift; // move every value one cell towards cell 0
	} mss_cmd_t;

endpackage

FILE: sv/mss_cell.sv
// One cell of the sorted insertion chain: holds one sample value.
// Depends on mss_pkg for the command struct.
module mss_cell
	import mss_pkg::*;
#(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                   clk,
	input  mss_cmd_t               cmd,
	input  logic [SAMPLE_BITS-1:0] x,
	input  logic                   occ,
	input  logic                   prev_keep,
	input  logic [SAMPLE_BITS-1:0] prev_val,
	input  logic [SAMPLE_BITS-1:0] next_val,
	output logic [SAMPLE_BITS-1:0] val,
	output logic                   keep
);

	logic [SAMPLE_BITS-1:0] val_q;

	// hold the value when it is occupied and not above the new sample
	assign keep = occ && (val_q <= x);
	assign val  = val_q;

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (!keep) begin
				val_q <= prev_keep ? x : prev_val;
			end
		end else if (cmd.shift) begin
			val_q <= next_val;
		end
	end

endmodule

FILE: sv/median_of_sample_set_core.sv
// Top level of the median-of-sample-set block: sorted insertion chain,
// drain sequencer and output register. Depends on mss_pkg and mss_cell.
//
//  channel | direction | tdata                          | tuser       | tlast
//  --------+-----------+--------------------------------+-------------+-----------
//  s_      | in        | sample[15:0]                   | has_sample  | last
//  m_      | out       | median_twice, set_size, ovfl   | -           | -
//
// Items without last are taken back to back while idle; each sample is
// placed in order by the chain of MAX_SAMPLES cells as its item is taken.
// An item with last then shifts the chain towards cell 0 by
// (n-1)/2 cells, rounded down (n = samples held, none for an empty set),
// so that the middle value(s) reach cells 0 and 1, and then loads the output
// register once no earlier result is waiting or that result is being taken.
// Reset clears the sample count, the overflow flag and the output valid;
// the cell values hold no reset and are only read below the count.
// A stalled output holds its item; inputs are taken again once the result
// is loaded, while it still waits on m_tready.
module median_of_sample_set_core
	import mss_pkg::*;
#(
	parameter int MAX_SAMPLES = 256,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // [15:0] sample
	input  logic                  s_tuser,  // [0] has_sample
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata   // [16:0] median_twice, [25:17] set_size,
	                                        // [26] overflow, [31:27] zero
);

	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_DRAIN
	} state_t;

	state_t                 state_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       shift_q;
	logic                   dropped_q;
	logic                   m_tvalid_q;
	logic [OUT_DATA_W-1:0]  m_tdata_q;

	logic                   s_acc;
	logic                   full;
	logic                   ins;
	logic [CNT_W-1:0]       new_count;
	logic [CNT_W-1:0]       half;
	logic [CNT_W-1:0]       shifts;
	logic                   out_free;
	logic                   load;
	logic [SAMPLE_BITS-1:0] x;
	logic [SAMPLE_BITS:0]   med_sum;
	logic [MEDIAN_W-1:0]    median;
	logic [SIZE_W-1:0]      size_out;
	logic [OUT_DATA_W-1:0]  result_word;
	mss_cmd_t               cmd;

	logic [SAMPLE_BITS-1:0] cell_val [MAX_SAMPLES];
	logic [MAX_SAMPLES-1:0] cell_keep;
	logic [MAX_SAMPLES-1:0] cell_occ;

	// Input handshake: take items only while no close is being drained
	assign s_tready  = (state_q == ST_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign full      = (count_q == CNT_W'(MAX_SAMPLES));
	assign ins       = s_acc && s_tuser && !full;
	assign new_count = count_q + CNT_W'(ins);
	assign x         = SAMPLE_BITS'(s_tdata[SAMPLE_W-1:0]);

	// Shifts that bring index (n-1)/2 to cell 0
	assign half   = new_count >> 1;
	assign shifts = new_count[0] ? half :
	                ((new_count == '0) ? '0 : half - CNT_W'(1));

	assign out_free = !m_tvalid_q || m_tready;
	assign load     = (state_q == ST_DRAIN) && (shift_q == '0) && out_free;

	assign cmd.ins   = ins;
	assign cmd.shift = (state_q == ST_DRAIN) && (shift_q != '0);

	// Chain of cells, cell 0 holds the smallest value
	for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
		logic                   prev_keep;
		logic [SAMPLE_BITS-1:0] prev_val;
		logic [SAMPLE_BITS-1:0] next_val;

		assign cell_occ[i] = (count_q > CNT_W'(i));

		if (i == 0) begin : g_first
			assign prev_keep = 1'b1;
			assign prev_val  = x;
		end else begin : g_mid
			assign prev_keep = cell_keep[i-1];
			assign prev_val  = cell_val[i-1];
		end

		if (i == MAX_SAMPLES - 1) begin : g_end
			assign next_val = cell_val[i];
		end else begin : g_inner
			assign next_val = cell_val[i+1];
		end

		mss_cell #(
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.x         (x),
			.occ       (cell_occ[i]),
			.prev_keep (prev_keep),
			.prev_val  (prev_val),
			.next_val  (next_val),
			.val       (cell_val[i]),
			.keep      (cell_keep[i])
		);
	end

	// Median (doubled) from cell 0, or from cells 0 and 1 for an even count, once drained
	always_comb begin
		if (count_q == '0) begin
			med_sum = '0;
		end else if (count_q[0]) begin
			med_sum = {cell_val[0], 1'b0};
		end else begin
			med_sum = {1'b0, cell_val[0]} + {1'b0, cell_val[1]};
		end
	end

	assign median   = MEDIAN_W'(med_sum);
	assign size_out = SIZE_W'(count_q);

	// Pack the result fields, zero above the overflow bit
	always_comb begin
		result_word                         = '0;
		result_word[MEDIAN_LSB +: MEDIAN_W] = median;
		result_word[SIZE_LSB +: SIZE_W]     = size_out;
		result_word[OVF_BIT]                = dropped_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			shift_q    <= '0;
			dropped_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			// raise valid on a new result, drop it once taken
			if (load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						count_q <= new_count;
						if (s_tuser && full) begin
							dropped_q <= 1'b1;
						end
						if (s_tlast) begin
							shift_q <= shifts;
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (shift_q != '0) begin
						shift_q <= shift_q - CNT_W'(1);
					end else if (out_free) begin
						// load the result, then clear the set
						m_tdata_q  <= result_word;
						count_q    <= '0;
						dropped_q  <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// The count never passes the capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_SAMPLES))
	else $error("sample count above capacity");

	// A loaded result always leaves an empty set behind
	a_clear_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (count_q == '0) && !dropped_q && m_tvalid)
	else $error("set not cleared after result");

	// The two lowest held values stay in order between items
	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) && (count_q >= CNT_W'(2)) |-> cell_val[0] <= cell_val[1])
	else $error("chain out of order");

	// Samples are only ever dropped from a full store
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dropped_q) |-> full)
	else $error("sample dropped below capacity");

endmodule
